### rtl/gblur_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the 3x3 binomial blur
package gblur_pkg;

   localparam int PIX_W      = 24;
   localparam int CHAN_W     = 8;
   localparam int CSR_DATA_W = 12;
   localparam int PEND_W     = 12;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [PEND_W-1:0]     PEND_MAX     = 12'd4095;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // source of a result pixel
   typedef enum logic [1:0] {
      SEL_BLUR,
      SEL_HELD,
      SEL_LINE
   } sel_type;

   typedef logic [8:0][CHAN_W-1:0] taps_type;

   // kernel 1 2 1 / 2 4 2 / 1 2 1 as shift amounts
   localparam logic [1:0] KERNEL_SHIFT [9] = '{2'd0, 2'd1, 2'd0,
                                               2'd1, 2'd2, 2'd1,
                                               2'd0, 2'd1, 2'd0};

   function automatic logic [CHAN_W-1:0] blur_channel(input taps_type taps);
      logic [11:0] sum;
      sum = '0;
      for (int k = 0; k < 9; k++) begin
         sum = sum + (12'(taps[k]) << KERNEL_SHIFT[k]);
      end
      return sum[11:4];
   endfunction

endpackage

### rtl/gblur_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces of the blur
interface gblur_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] chan_a;
   logic [7:0] chan_b;
   logic [7:0] chan_c;

   modport source (output valid, output kind, output chan_a, output chan_b, output chan_c,
                   input ready);
   modport sink   (input valid, input kind, input chan_a, input chan_b, input chan_c,
                   output ready);
endinterface

interface gblur_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_a;
   logic [7:0] out_b;
   logic [7:0] out_c;
   logic       frame_end;

   modport source (output valid, output out_a, output out_b, output out_c,
                   output frame_end, input ready);
   modport sink   (input valid, input out_a, input out_b, input out_c,
                   input frame_end, output ready);
endinterface

### rtl/gaussian_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// streaming 3x3 binomial blur for three-channel pixels
// a taken request passes through the second-stage registers into the result register
// pixel results lag their input by frame_width+1 pixels, drained by flush requests
// throughput: one request per cycle, limited only by the result register
// reset: synchronous, clears counters, window and valid flags; line stores are not cleared
module gaussian_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [0:0]                         csr_index,
   input  logic [gblur_pkg::CSR_DATA_W-1:0]   csr_wdata,
   gblur_req_if.sink                          req_chan,
   gblur_rsp_if.source                        rsp_chan
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int DWA   = $clog2(MAX_WIDTH + 1);
   localparam int DHA   = $clog2(MAX_HEIGHT + 1);
   localparam int DIM_W = (DWA > gblur_pkg::CSR_DATA_W) ? DWA : gblur_pkg::CSR_DATA_W;
   localparam int DIM_H = (DHA > gblur_pkg::CSR_DATA_W) ? DHA : gblur_pkg::CSR_DATA_W;
   localparam int PW    = gblur_pkg::PIX_W;
   localparam int CW    = gblur_pkg::CHAN_W;
   localparam int NW    = gblur_pkg::PEND_W;

   // configuration
   logic [gblur_pkg::CSR_DATA_W-1:0] wid_cfg_ff, hgt_cfg_ff;
   logic [DIM_W-1:0]                 w_eff;
   logic [DIM_H-1:0]                 h_eff;

   // position and pending count
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [NW-1:0]    pend_ff, pend_in;

   // second stage
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_flush_ff, s2_emit_ff, s2_last_ff;
   gblur_pkg::sel_type   s2_sel_ff;
   logic [PW-1:0]        s2_px_ff;
   logic [COL_W-1:0]     s2_addr_ff;

   // line stores and bypass
   logic [PW-1:0] upper_mem [MAX_WIDTH];
   logic [PW-1:0] middle_mem [MAX_WIDTH];
   logic [PW-1:0] upper_rd_ff, middle_rd_ff;
   logic          byp_hit_ff;
   logic [PW-1:0] byp_upper_ff, byp_middle_ff;
   logic [PW-1:0] up_px, mid_px;

   // window and result
   logic [PW-1:0] win_ff [9];
   logic [PW-1:0] win_in [9];
   logic [PW-1:0] blur_px, res_px;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_px_ff;
   logic          rsp_last_ff;

   // first stage decode
   logic               req_ready, req_fire, out_free, s2_adv, mem_wr;
   logic               frame_start, send_px, blur_pos, flush_ok, from_line;
   logic [NW-1:0]      p0, p1, p2;
   logic [DIM_W-1:0]   pend_ext, col_inc;
   logic [DIM_H-1:0]   row_inc;
   logic [COL_W-1:0]   flush_idx, rd_addr;
   gblur_pkg::sel_type sel_in;
   logic               emit_in, last_in;
   logic [PW-1:0]      req_px;

   // effective frame size
   always_comb begin
      if (wid_cfg_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (DIM_W'(wid_cfg_ff) > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = DIM_W'(wid_cfg_ff);
      end
      if (hgt_cfg_ff == '0) begin
         h_eff = DIM_H'(1);
      end else if (DIM_H'(hgt_cfg_ff) > DIM_H'(MAX_HEIGHT)) begin
         h_eff = DIM_H'(MAX_HEIGHT);
      end else begin
         h_eff = DIM_H'(hgt_cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_cfg_ff <= gblur_pkg::WIDTH_RESET;
         hgt_cfg_ff <= gblur_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gblur_pkg::CSR_FRAME_WIDTH:  wid_cfg_ff <= csr_wdata;
            gblur_pkg::CSR_FRAME_HEIGHT: hgt_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s2_adv         = s2_valid_ff && (!s2_emit_ff || out_free);
   assign req_ready      = !s2_valid_ff || s2_adv;
   assign req_fire       = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign mem_wr         = s2_adv && !s2_flush_ff;
   assign req_px         = {req_chan.chan_c, req_chan.chan_b, req_chan.chan_a};

   // first stage: position, pending count and result source
   always_comb begin
      frame_start = (col_ff == '0) && (row_ff == '0);
      send_px     = ((col_ff != '0) && (row_ff != '0)) ||
                    ((col_ff == '0) && (row_ff >= ROW_W'(2)));
      blur_pos    = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      flush_ok    = frame_start && (pend_ff != '0);
      pend_ext    = DIM_W'(pend_ff);
      from_line   = !(pend_ext > w_eff);
      flush_idx   = COL_W'(w_eff - pend_ext);

      p0 = frame_start ? '0 : pend_ff;
      p1 = (p0 != gblur_pkg::PEND_MAX) ? p0 + NW'(1) : p0;
      p2 = send_px ? p1 - NW'(1) : p1;

      col_inc = DIM_W'(col_ff) + DIM_W'(1);
      row_inc = DIM_H'(row_ff) + DIM_H'(1);

      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (req_fire && !req_chan.kind) begin
         pend_in = p2;
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
         end else begin
            col_in = COL_W'(col_inc);
         end
      end else if (req_fire && flush_ok) begin
         pend_in = pend_ff - NW'(1);
      end

      if (req_chan.kind) begin
         emit_in = 1'b1;
         sel_in  = from_line ? gblur_pkg::SEL_LINE : gblur_pkg::SEL_HELD;
         last_in = (pend_ff == NW'(1));
         rd_addr = flush_idx;
      end else begin
         emit_in = send_px;
         sel_in  = blur_pos ? gblur_pkg::SEL_BLUR : gblur_pkg::SEL_HELD;
         last_in = 1'b0;
         rd_addr = col_ff;
      end

      if (req_fire) begin
         s2_valid_in = !req_chan.kind || flush_ok;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pend_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pend_ff     <= pend_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s2_flush_ff <= req_chan.kind;
         s2_emit_ff  <= emit_in;
         s2_sel_ff   <= sel_in;
         s2_last_ff  <= last_in;
         s2_px_ff    <= req_px;
         s2_addr_ff  <= rd_addr;
      end
   end

   // line stores with write-to-read bypass
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         upper_mem[s2_addr_ff]  <= mid_px;
         middle_mem[s2_addr_ff] <= s2_px_ff;
      end
      if (req_fire) begin
         upper_rd_ff  <= upper_mem[rd_addr];
         middle_rd_ff <= middle_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byp_hit_ff    <= mem_wr && (s2_addr_ff == rd_addr);
         byp_upper_ff  <= mid_px;
         byp_middle_ff <= s2_px_ff;
      end
   end

   assign up_px  = byp_hit_ff ? byp_upper_ff  : upper_rd_ff;
   assign mid_px = byp_hit_ff ? byp_middle_ff : middle_rd_ff;

   // window shift and kernel
   always_comb begin
      gblur_pkg::taps_type taps;
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = up_px;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = mid_px;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s2_px_ff;
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 9; k++) begin
            taps[k] = win_in[k][CW*ch +: CW];
         end
         blur_px[CW*ch +: CW] = gblur_pkg::blur_channel(taps);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (mem_wr) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // result register
   always_comb begin
      case (s2_sel_ff)
         gblur_pkg::SEL_BLUR: res_px = blur_px;
         gblur_pkg::SEL_HELD: res_px = win_ff[5];
         gblur_pkg::SEL_LINE: res_px = mid_px;
         default:             res_px = win_ff[5];
      endcase
      if (s2_adv && s2_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s2_emit_ff) begin
         rsp_px_ff   <= res_px;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_a     = rsp_px_ff[CW-1:0];
   assign rsp_chan.out_b     = rsp_px_ff[2*CW-1:CW];
   assign rsp_chan.out_c     = rsp_px_ff[3*CW-1:2*CW];
   assign rsp_chan.frame_end = rsp_last_ff;

endmodule

### rtl/gblur_checker.sv
`timescale 1ns / 1ps
// port checker for the blur and its bind
module gblur_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_a,
   input logic [7:0] rsp_out_b,
   input logic [7:0] rsp_out_c,
   input logic       rsp_frame_end
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_a) && $stable(rsp_out_b) &&
      $stable(rsp_out_c) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // request side only blocks behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request blocked without result stall");

   // a fresh result comes from an earlier taken request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching request");

   // no result straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gaussian_blur_3x3_rgb gblur_checker u_gblur_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_a     (rsp_chan.out_a),
   .rsp_out_b     (rsp_chan.out_b),
   .rsp_out_c     (rsp_chan.out_c),
   .rsp_frame_end (rsp_chan.frame_end)
);

### verif/blur_tb_pkg.sv
`timescale 1ns / 1ps
// request kind codes shared by the blur checker and the testbench top
package blur_tb_pkg;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

endpackage

### verif/blur_checker.sv
`timescale 1ns / 1ps
// checker of the blur: predicts each result from the requests and compares it
module blur_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [0:0]                       csr_index,
   input  logic [gblur_pkg::CSR_DATA_W-1:0] csr_wdata,
   gblur_req_if                             req_mon,
   gblur_rsp_if                             rsp_mon,
   output int                               fail_count,
   output int                               results_waiting,
   output int                               results_checked
);

   localparam int          CW       = gblur_pkg::CHAN_W;
   localparam int          PW       = gblur_pkg::PIX_W;
   localparam int          DW       = gblur_pkg::CSR_DATA_W;
   localparam int unsigned LINE_MAX = 2048;
   localparam int unsigned BLUR_WEIGHT [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

   typedef struct packed {
      logic [CW-1:0] out_a;
      logic [CW-1:0] out_b;
      logic [CW-1:0] out_c;
      logic          frame_end;
   } blur_result_type;

   blur_result_type expected_pixels [$];
   logic [DW-1:0]   width_reg;
   logic [DW-1:0]   height_reg;
   logic [PW-1:0]   upper_line [LINE_MAX];
   logic [PW-1:0]   middle_line [LINE_MAX];
   logic [PW-1:0]   win [9];
   int unsigned     col_pos;
   int unsigned     row_pos;
   int unsigned     pending;

   function automatic int unsigned clamp_dim(input logic [DW-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > LINE_MAX) begin
         return LINE_MAX;
      end
      return v;
   endfunction

   function automatic logic [PW-1:0] blur_window();
      int unsigned   sum;
      logic [PW-1:0] px;
      px = '0;
      for (int sh = 0; sh < PW; sh += CW) begin
         sum = 0;
         for (int k = 0; k < 9; k++) begin
            sum += BLUR_WEIGHT[k] * win[k][sh +: CW];
         end
         px[sh +: CW] = CW'(sum >> 4);
      end
      return px;
   endfunction

   task automatic push_pixel(input logic [PW-1:0] px, input logic last);
      blur_result_type item;
      item = '{px[7:0], px[15:8], px[23:16], last};
      expected_pixels.push_back(item);
   endtask

   task automatic predict_request(input blur_tb_pkg::req_kind_type kind,
                                  input logic [PW-1:0] px);
      int unsigned   w;
      int unsigned   h;
      logic [PW-1:0] up;
      logic [PW-1:0] mid;
      logic [PW-1:0] prev_right;
      logic [PW-1:0] value;
      bit            send;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      send = 1'b0;
      value = '0;
      if (kind == blur_tb_pkg::REQ_FLUSH) begin
         // only drains between frames, and only while something is held
         if (row_pos != 0 || col_pos != 0 || pending == 0) begin
            return;
         end
         value = (pending > w) ? win[5] : middle_line[w - pending];
         pending--;
         push_pixel(value, pending == 0);
         return;
      end
      if (row_pos == 0 && col_pos == 0) begin
         pending = 0;
      end
      prev_right = win[5];
      up = upper_line[col_pos];
      mid = middle_line[col_pos];
      upper_line[col_pos] = mid;
      middle_line[col_pos] = px;
      for (int r = 0; r < 3; r++) begin
         win[r * 3] = win[r * 3 + 1];
         win[r * 3 + 1] = win[r * 3 + 2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      if (pending < gblur_pkg::PEND_MAX) begin
         pending++;
      end
      if (col_pos >= 1 && row_pos >= 1) begin
         send = 1'b1;
         value = (row_pos >= 2 && col_pos >= 2) ? blur_window() : win[4];
      end else if (col_pos == 0 && row_pos >= 2) begin
         send = 1'b1;
         value = prev_right;
      end
      if (send && pending > 0) begin
         pending--;
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
         end
      end
      if (send) begin
         push_pixel(value, 1'b0);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      blur_result_type want;
      if (expected_pixels.size() == 0) begin
         $error("unexpected result: out_a %0d out_b %0d out_c %0d frame_end %0d",
                rsp_mon.out_a, rsp_mon.out_b, rsp_mon.out_c, rsp_mon.frame_end);
         fail_count++;
         return;
      end
      want = expected_pixels.pop_front();
      results_checked++;
      check_field("out_a", want.out_a, rsp_mon.out_a);
      check_field("out_b", want.out_b, rsp_mon.out_b);
      check_field("out_c", want.out_c, rsp_mon.out_c);
      check_field("frame_end", 8'(want.frame_end), 8'(rsp_mon.frame_end));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = gblur_pkg::WIDTH_RESET;
         height_reg = gblur_pkg::HEIGHT_RESET;
         col_pos = 0;
         row_pos = 0;
         pending = 0;
         for (int k = 0; k < 9; k++) begin
            win[k] = '0;
         end
         for (int i = 0; i < LINE_MAX; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         expected_pixels.delete();
         fail_count = 0;
         results_checked = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
         if (csr_wr_en) begin
            case (gblur_pkg::csr_index_type'(csr_index))
               gblur_pkg::CSR_FRAME_WIDTH: begin
                  width_reg = csr_wdata;
               end
               gblur_pkg::CSR_FRAME_HEIGHT: begin
                  height_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(blur_tb_pkg::req_kind_type'(req_mon.kind),
                            {req_mon.chan_c, req_mon.chan_b, req_mon.chan_a});
         end
      end
      results_waiting = expected_pixels.size();
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench top of the blur: request stimulus, register set-up and verdict
module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int ITEM_TARGET    = 440;
   localparam int CW             = gblur_pkg::CHAN_W;
   localparam int PW             = gblur_pkg::PIX_W;
   localparam int DW             = gblur_pkg::CSR_DATA_W;

   typedef enum {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_SINK_STALLS,
      PH_BOTH_IDLE
   } idle_phase_type;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   logic [0:0]    csr_index;
   logic [DW-1:0] csr_wdata;

   gblur_req_if req_if ();
   gblur_rsp_if rsp_if ();

   int          fail_count;
   int          results_waiting;
   int          results_checked;
   int unsigned send_gap_pct;
   int unsigned sink_stall_pct;
   int unsigned cur_w;
   int unsigned cur_h;
   int unsigned pixels_sent;
   int unsigned flushes_sent;
   int unsigned frames_sent;
   int unsigned quiet_cycles;

   gaussian_blur_3x3_rgb u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   blur_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .fail_count      (fail_count),
      .results_waiting (results_waiting),
      .results_checked (results_checked)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned dim_of(input logic [DW-1:0] v);
      if (v == 0) begin
         return 1;
      end
      return (v > 2048) ? 2048 : v;
   endfunction

   function automatic logic [PW-1:0] random_pixel();
      logic [PW-1:0] px;
      for (int sh = 0; sh < PW; sh += CW) begin
         case ($urandom_range(9))
            0: begin
               px[sh +: CW] = 8'h00;
            end
            1: begin
               px[sh +: CW] = 8'hFF;
            end
            default: begin
               px[sh +: CW] = 8'($urandom);
            end
         endcase
      end
      return px;
   endfunction

   task automatic set_phase(input idle_phase_type ph);
      case (ph)
         PH_STEADY: begin
            send_gap_pct = 0;
            sink_stall_pct = 0;
         end
         PH_SEND_GAPS: begin
            send_gap_pct = 62;
            sink_stall_pct = 0;
         end
         PH_SINK_STALLS: begin
            send_gap_pct = 0;
            sink_stall_pct = 62;
         end
         default: begin
            send_gap_pct = 36;
            sink_stall_pct = 36;
         end
      endcase
   endtask

   task automatic send_request(input blur_tb_pkg::req_kind_type kind,
                               input logic [PW-1:0] px);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.kind = kind;
      req_if.chan_a = px[7:0];
      req_if.chan_b = px[15:8];
      req_if.chan_c = px[23:16];
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (kind == blur_tb_pkg::REQ_FLUSH) begin
         flushes_sent++;
      end else begin
         pixels_sent++;
      end
   endtask

   // hold off requests until every result is out and the pipeline is empty
   task automatic settle();
      req_if.valid = 1'b0;
      while (results_waiting != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input gblur_pkg::csr_index_type idx, input logic [DW-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == gblur_pkg::CSR_FRAME_WIDTH) begin
         cur_w = dim_of(value);
      end else begin
         cur_h = dim_of(value);
      end
   endtask

   task automatic configure(input logic [DW-1:0] w_val, input logic [DW-1:0] h_val);
      settle();
      write_reg(gblur_pkg::CSR_FRAME_WIDTH, w_val);
      write_reg(gblur_pkg::CSR_FRAME_HEIGHT, h_val);
   endtask

   task automatic send_frame(input bit drain, input bit stray_flush, input bit reshape);
      int unsigned col;
      int unsigned row;
      bit          done;
      bit          reshaped;
      col = 0;
      row = 0;
      done = 1'b0;
      reshaped = 1'b0;
      while (!done) begin
         // flush in mid frame, must be ignored
         if (stray_flush && (col != 0 || row != 0) && $urandom_range(19) == 0) begin
            send_request(blur_tb_pkg::REQ_FLUSH, random_pixel());
         end
         // height change while a frame is partly received
         if (reshape && !reshaped && row == 1 && col == 0) begin
            settle();
            write_reg(gblur_pkg::CSR_FRAME_HEIGHT, DW'($urandom_range(1, 4)));
            reshaped = 1'b1;
         end
         send_request(blur_tb_pkg::REQ_PIXEL, random_pixel());
         col++;
         if (col >= cur_w) begin
            col = 0;
            row++;
            if (row >= cur_h) begin
               done = 1'b1;
            end
         end
      end
      frames_sent++;
      if (drain) begin
         repeat (cur_w + 1 + $urandom_range(2)) begin
            send_request(blur_tb_pkg::REQ_FLUSH, random_pixel());
         end
      end
   endtask

   initial begin
      int ph;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = gblur_pkg::CSR_FRAME_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = blur_tb_pkg::REQ_PIXEL;
      req_if.chan_a = '0;
      req_if.chan_b = '0;
      req_if.chan_c = '0;
      send_gap_pct = 0;
      sink_stall_pct = 0;
      cur_w = dim_of(gblur_pkg::WIDTH_RESET);
      cur_h = dim_of(gblur_pkg::HEIGHT_RESET);
      pixels_sent = 0;
      flushes_sent = 0;
      frames_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: 3x3 frames with extreme pixels
      set_phase(PH_STEADY);
      configure(12'd3, 12'd3);
      send_request(blur_tb_pkg::REQ_FLUSH, 24'hFFFFFF);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) begin
            send_request(blur_tb_pkg::REQ_FLUSH, 24'h000000);
         end
         send_request(blur_tb_pkg::REQ_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
      end
      // next frame starts before the previous one is drained
      for (int i = 0; i < 9; i++) begin
         send_request(blur_tb_pkg::REQ_PIXEL, (i == 4) ? 24'h00FF80 : 24'hFFFFFF);
      end
      repeat (5) send_request(blur_tb_pkg::REQ_FLUSH, 24'h5A5A5A);

      // register extremes: zero sizes, and a saturated height cut short
      set_phase(PH_SINK_STALLS);
      configure(12'd0, 12'd0);
      send_frame(1'b1, 1'b0, 1'b0);
      set_phase(PH_SEND_GAPS);
      configure(12'd0, 12'd5);
      send_frame(1'b1, 1'b0, 1'b0);
      set_phase(PH_STEADY);
      configure(12'd6, 12'd0);
      send_frame(1'b1, 1'b1, 1'b0);
      set_phase(PH_BOTH_IDLE);
      configure(12'd3, 12'd4095);
      send_frame(1'b1, 1'b0, 1'b1);

      // random small frames
      ph = 0;
      while (pixels_sent + flushes_sent < ITEM_TARGET) begin
         set_phase(idle_phase_type'(ph % 4));
         ph++;
         configure(DW'($urandom_range(0, 9)), DW'($urandom_range(0, 7)));
         if ($urandom_range(3) == 0) begin
            send_frame(1'b0, 1'b1, 1'b0);
         end
         send_frame(1'b1, 1'($urandom_range(1)), $urandom_range(4) == 0);
      end

      settle();
      $display("sent %0d pixel and %0d flush requests in %0d frames, checked %0d results",
               pixels_sent, flushes_sent, frames_sent, results_checked);
      $display("frames up to 9x7 with zero and saturated sizes, stray flushes, undrained");
      $display("frames and height changes mid frame, under sender gaps and receiver stalls");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
